// ===== hdl/atp_pkg.sv =====
package atp_pkg;

    localparam int unsigned THREADS    = 2;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned EVT_W      = 16;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned IVL_W      = 16;
    localparam int unsigned FUNC_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]  OCC_MAX = 7'd127;
    localparam logic [EVT_W-1:0]  EVT_MAX = 16'hFFFF;

    localparam logic [CNT_W-1:0]  SIZE_RESET     = 7'd64;
    localparam logic [CNT_W-1:0]  STEP_RESET     = 7'd1;
    localparam logic [CNT_W-1:0]  CAP_RESET      = 7'd64;
    localparam logic [IVL_W-1:0]  INTERVAL_RESET = 16'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 3'd0,
        FUNC_RELEASE = 3'd1,
        FUNC_FULLQ   = 3'd2,
        FUNC_FREEQ   = 3'd3,
        FUNC_TICK    = 3'd4,
        FUNC_CLEAR   = 3'd5
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE     = 2'd0,
        CFG_STEP     = 2'd1,
        CFG_CAP      = 2'd2,
        CFG_INTERVAL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0]  size_in_use;
        logic [CNT_W-1:0]  step_size;
        logic [CNT_W-1:0]  partition_cap;
        logic [IVL_W-1:0]  adapt_interval;
    } cfg_t;

    typedef struct packed {
        logic [THREADS-1:0][CNT_W-1:0] occ;
        logic [THREADS-1:0][CNT_W-1:0] lim;
        logic [THREADS-1:0][EVT_W-1:0] evt;
        logic [TICK_W-1:0]             tick;
        logic [TICK_W-1:0]             last;
    } part_state_t;

    typedef struct packed {
        logic             is_full;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] occupied_count;
        logic [CNT_W-1:0] partition_limit;
    } result_t;

endpackage

// ===== hdl/atp_if.sv =====
interface atp_op_if;
    logic                         valid;
    logic                         ready;
    logic [atp_pkg::FUNC_W-1:0]   func;
    logic                         thread;

    modport source (output valid, output func, output thread, input ready);
    modport sink   (input valid, input func, input thread, output ready);
endinterface

interface atp_res_if;
    logic                         valid;
    logic                         ready;
    logic                         is_full;
    logic [atp_pkg::CNT_W-1:0]    free_count;
    logic [atp_pkg::CNT_W-1:0]    occupied_count;
    logic [atp_pkg::CNT_W-1:0]    partition_limit;

    modport source (output valid, output is_full, output free_count,
                    output occupied_count, output partition_limit, input ready);
    modport sink   (input valid, input is_full, input free_count,
                    input occupied_count, input partition_limit, output ready);
endinterface

interface atp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [atp_pkg::CFG_IDX_W-1:0]    index;
    logic [atp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/adaptive_two_thread_partition_top.sv =====
// An operation transaction reaches the result through the input register and then the result register.
// Throughput: one operation per cycle while the result side is ready; the partition
// state update sits in one combinational pass between the two registers.
// Reset (rst_n low, asynchronous): configuration registers return to their defaults, limits to half of
// size_in_use, occupancy, full events and tick counters to zero, pipeline emptied.
module adaptive_two_thread_partition_top (
    input  logic        clk,
    input  logic        rst_n,
    atp_op_if.sink      op,
    atp_res_if.source   res,
    atp_cfg_if.sink     cfg
);

    atp_pkg::cfg_t                 cfg_reg;
    atp_pkg::part_state_t          state_reg;
    atp_pkg::part_state_t          state_next;
    atp_pkg::result_t              res_next;
    atp_pkg::result_t              res_reg;
    logic                          res_valid_reg;
    logic                          in_valid_reg;
    logic [atp_pkg::FUNC_W-1:0]    func_reg;
    logic                          thread_reg;
    logic                          advance;

    assign advance   = in_valid_reg && (!res_valid_reg || res.ready);
    assign op.ready  = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    atp_update u_update (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .func   (func_reg),
        .thread (thread_reg),
        .nxt    (state_next),
        .res    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_in_use    <= atp_pkg::SIZE_RESET;
            cfg_reg.step_size      <= atp_pkg::STEP_RESET;
            cfg_reg.partition_cap  <= atp_pkg::CAP_RESET;
            cfg_reg.adapt_interval <= atp_pkg::INTERVAL_RESET;
        end
        else if (cfg.valid)
        begin
            case (atp_pkg::cfg_idx_t'(cfg.index))
                atp_pkg::CFG_SIZE:     cfg_reg.size_in_use    <= cfg.data[atp_pkg::CNT_W-1:0];
                atp_pkg::CFG_STEP:     cfg_reg.step_size      <= cfg.data[atp_pkg::CNT_W-1:0];
                atp_pkg::CFG_CAP:      cfg_reg.partition_cap  <= cfg.data[atp_pkg::CNT_W-1:0];
                atp_pkg::CFG_INTERVAL: cfg_reg.adapt_interval <= cfg.data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.occ  <= '0;
            state_reg.lim  <= {atp_pkg::SIZE_RESET >> 1, atp_pkg::SIZE_RESET >> 1};
            state_reg.evt  <= '0;
            state_reg.tick <= '0;
            state_reg.last <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (op.ready)
            begin
                in_valid_reg <= op.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid && op.ready)
        begin
            func_reg   <= op.func;
            thread_reg <= op.thread;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.is_full         = res_reg.is_full;
    assign res.free_count      = res_reg.free_count;
    assign res.occupied_count  = res_reg.occupied_count;
    assign res.partition_limit = res_reg.partition_limit;

endmodule

// ===== hdl/atp_update.sv =====
module atp_update (
    input  atp_pkg::cfg_t                     cfg,
    input  atp_pkg::part_state_t              cur,
    input  logic [atp_pkg::FUNC_W-1:0]        func,
    input  logic                              thread,
    output atp_pkg::part_state_t              nxt,
    output atp_pkg::result_t                  res
);

    logic [atp_pkg::CNT_W-1:0]   occ_t;
    logic [atp_pkg::CNT_W-1:0]   occ_inc;
    logic [atp_pkg::CNT_W-1:0]   occ_dec;
    logic [atp_pkg::CNT_W-1:0]   half_size;
    logic [atp_pkg::TICK_W-1:0]  base;
    logic [atp_pkg::TICK_W:0]    due_at;
    logic                        due;
    logic                        grow;
    logic                        shrink;
    logic [atp_pkg::CNT_W:0]     grown;
    logic                        fits;
    logic [atp_pkg::CNT_W:0]     occ_need;
    atp_pkg::part_state_t        rel;
    logic [atp_pkg::CNT_W-1:0]   occ_o;
    logic [atp_pkg::CNT_W-1:0]   lim_o;

    assign occ_t     = cur.occ[thread];
    assign occ_inc   = (occ_t < atp_pkg::OCC_MAX) ? occ_t + 7'd1 : occ_t;
    assign occ_dec   = (occ_t != '0) ? occ_t - 7'd1 : occ_t;
    assign half_size = {1'b0, cfg.size_in_use[atp_pkg::CNT_W-1:1]};

    // release path with adaptation check
    assign base   = (cur.last == '0) ? cur.tick : cur.last;
    assign due_at = {1'b0, base} + {{(atp_pkg::TICK_W-atp_pkg::IVL_W+1){1'b0}},
                                    cfg.adapt_interval};
    assign due    = {1'b0, cur.tick} >= due_at;
    assign grow   = cur.evt[1] > cur.evt[0];
    assign shrink = ~grow;

    always_comb
    begin
        rel = cur;
        rel.occ[thread] = occ_dec;
        rel.last = base;
        grown    = {1'b0, cur.lim[grow]} + {1'b0, cfg.step_size};
        occ_need = {1'b0, rel.occ[shrink]} + {1'b0, cfg.step_size};
        fits     = (grown < {1'b0, cfg.partition_cap})
                && (cur.lim[shrink] >= cfg.step_size)
                && (occ_need <= {1'b0, cur.lim[shrink]});
        if (due)
        begin
            rel.last = cur.tick;
            if (cur.evt[0] != cur.evt[1])
            begin
                rel.evt[0] = '0;
                rel.evt[1] = '0;
                if (fits)
                begin
                    rel.lim[shrink] = cur.lim[shrink] - cfg.step_size;
                    rel.lim[grow]   = grown[atp_pkg::CNT_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        nxt = cur;
        case (atp_pkg::func_t'(func))
            atp_pkg::FUNC_ALLOC:
            begin
                nxt.occ[thread] = occ_inc;
                if (occ_inc == cur.lim[thread] && cur.evt[thread] != atp_pkg::EVT_MAX)
                begin
                    nxt.evt[thread] = cur.evt[thread] + 16'd1;
                end
            end
            atp_pkg::FUNC_RELEASE:
            begin
                nxt = rel;
            end
            atp_pkg::FUNC_FULLQ,
            atp_pkg::FUNC_FREEQ:
            begin
                if (occ_t >= cur.lim[thread] && cur.evt[thread] != atp_pkg::EVT_MAX)
                begin
                    nxt.evt[thread] = cur.evt[thread] + 16'd1;
                end
            end
            atp_pkg::FUNC_TICK:
            begin
                nxt.tick = cur.tick + 32'd1;
            end
            atp_pkg::FUNC_CLEAR:
            begin
                nxt.occ  = '0;
                nxt.lim  = {half_size, half_size};
                nxt.evt  = '0;
                nxt.last = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign occ_o = nxt.occ[thread];
    assign lim_o = nxt.lim[thread];

    always_comb
    begin
        res.is_full         = occ_o >= lim_o;
        res.free_count      = (lim_o > occ_o) ? lim_o - occ_o : '0;
        res.occupied_count  = occ_o;
        res.partition_limit = lim_o;
    end

endmodule

// ===== tb/sv/partition_status_checker.sv =====
module partition_status_checker
    import atp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    atp_op_if    op,
    atp_res_if   res,
    atp_cfg_if   cfg,
    output int   fails,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CNT_W-1:0]  size_q;
    logic [CNT_W-1:0]  step_q;
    logic [CNT_W-1:0]  cap_q;
    logic [IVL_W-1:0]  ivl_q;

    logic [CNT_W-1:0]  occ [THREADS];
    logic [CNT_W-1:0]  lim [THREADS];
    logic [EVT_W-1:0]  evt [THREADS];
    logic [TICK_W-1:0] ticks;
    logic [TICK_W-1:0] last_decision;

    result_t status_q [$];

    task automatic reset_partitions();
        int i;
        for (i = 0; i < THREADS; i++)
        begin
            occ[i] = '0;
            lim[i] = size_q >> 1;
            evt[i] = '0;
        end
        last_decision = '0;
    endtask

    task automatic bump_full(input logic th);
        if (evt[th] != EVT_MAX)
            evt[th] = evt[th] + 1'b1;
    endtask

    task automatic rebalance();
        logic [TICK_W:0] due;
        int unsigned     g;
        int unsigned     s;
        if (last_decision == '0)
            last_decision = ticks;
        due = {1'b0, last_decision} + (TICK_W + 1)'(ivl_q);
        if ({1'b0, ticks} < due)
            return;
        last_decision = ticks;
        if (evt[0] == evt[1])
            return;
        g = (evt[0] > evt[1]) ? 0 : 1;
        s = 1 - g;
        evt[0] = '0;
        evt[1] = '0;
        if (int'(lim[g]) + int'(step_q) < int'(cap_q) &&
            int'(lim[s]) - int'(step_q) >= 0 &&
            int'(occ[s]) <= int'(lim[s]) - int'(step_q))
        begin
            lim[s] = lim[s] - step_q;
            lim[g] = lim[g] + step_q;
        end
    endtask

    task automatic apply_op(input logic [FUNC_W-1:0] f, input logic th, output result_t r);
        case (f)
            FUNC_ALLOC:
            begin
                if (occ[th] < OCC_MAX)
                    occ[th] = occ[th] + 1'b1;
                if (occ[th] == lim[th])
                    bump_full(th);
            end
            FUNC_RELEASE:
            begin
                if (occ[th] != '0)
                    occ[th] = occ[th] - 1'b1;
                rebalance();
            end
            FUNC_FULLQ, FUNC_FREEQ:
            begin
                if (occ[th] >= lim[th])
                    bump_full(th);
            end
            FUNC_TICK:
                ticks = ticks + 1'b1;
            FUNC_CLEAR:
                reset_partitions();
            default:
                ;
        endcase
        r.is_full         = (occ[th] >= lim[th]);
        r.free_count      = (lim[th] > occ[th]) ? lim[th] - occ[th] : '0;
        r.occupied_count  = occ[th];
        r.partition_limit = lim[th];
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_SIZE:     size_q = d[CNT_W-1:0];
            CFG_STEP:     step_q = d[CNT_W-1:0];
            CFG_CAP:      cap_q  = d[CNT_W-1:0];
            CFG_INTERVAL: ivl_q  = d[IVL_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            size_q = SIZE_RESET;
            step_q = STEP_RESET;
            cap_q  = CAP_RESET;
            ivl_q  = INTERVAL_RESET;
            ticks  = '0;
            reset_partitions();
            status_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                write_reg(cfg.index, cfg.data);
            if (res.valid && res.ready)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual full %0d free %0d occ %0d limit %0d",
                             $time, res.is_full, res.free_count, res.occupied_count,
                             res.partition_limit);
                    fails++;
                end
                else
                begin
                    want = status_q.pop_front();
                    compare_field("is_full", want.is_full, res.is_full);
                    compare_field("free_count", want.free_count, res.free_count);
                    compare_field("occupied_count", want.occupied_count, res.occupied_count);
                    compare_field("partition_limit", want.partition_limit, res.partition_limit);
                end
            end
            if (op.valid && op.ready)
            begin
                apply_op(op.func, op.thread, want);
                status_q.push_back(want);
            end
            pending <= status_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench
    import atp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;

    atp_op_if  op ();
    atp_res_if res ();
    atp_cfg_if cfg ();

    adaptive_two_thread_partition_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .res   (res),
        .cfg   (cfg)
    );

    partition_status_checker status_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .res     (res),
        .cfg     (cfg),
        .fails   (fails),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("testbench failed");
        $finish;
    end

    always @(posedge clk)
        res.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);

    task automatic send_op(input logic [FUNC_W-1:0] f, input logic th);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            op.valid <= 1'b0;
            @(posedge clk);
        end
        op.valid  <= 1'b1;
        op.func   <= f;
        op.thread <= th;
        do @(posedge clk); while (!op.ready);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic load_partition_regs(input int unsigned size, step, cap, ivl);
        write_reg(CFG_SIZE, CFG_DATA_W'(size));
        write_reg(CFG_STEP, CFG_DATA_W'(step));
        write_reg(CFG_CAP, CFG_DATA_W'(cap));
        write_reg(CFG_INTERVAL, CFG_DATA_W'(ivl));
        cfg.valid <= 1'b0;
    endtask

    // hold the sender until every outstanding transaction has returned
    task automatic drain();
        op.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        int               k;
        int               w;
        logic [FUNC_W-1:0] f;
        logic             th;
        th = 1'($urandom_range(1));
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 2)
                drain();
            if ($urandom_range(99) < 30)
                th = ~th;
            w = $urandom_range(99);
            if (w < 4)
            begin
                repeat ($urandom_range(1, 20)) send_op(FUNC_ALLOC, th);
                continue;
            end
            else if (w < 32)
                f = FUNC_ALLOC;
            else if (w < 56)
                f = FUNC_RELEASE;
            else if (w < 66)
                f = FUNC_FULLQ;
            else if (w < 76)
                f = FUNC_FREEQ;
            else if (w < 92)
                f = FUNC_TICK;
            else if (w < 94)
                f = FUNC_CLEAR;
            else
                f = FUNC_W'($urandom_range(7));
            send_op(f, th);
        end
    endtask

    initial
    begin
        int phase;
        int s;
        rst_n       = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        op.valid    = 1'b0;
        op.func     = FUNC_ALLOC;
        op.thread   = 1'b0;
        cfg.valid   = 1'b0;
        cfg.index   = CFG_SIZE;
        cfg.data    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 15;
        rx_idle_pct = 55;
        send_op(FUNC_FREEQ, 1'b0);
        send_op(FUNC_FULLQ, 1'b1);
        send_op(FUNC_SPARE_LO, 1'b0);
        send_op(FUNC_SPARE_HI, 1'b1);
        send_op(FUNC_RELEASE, 1'b0);
        send_op(FUNC_TICK, 1'b1);
        send_op(FUNC_ALLOC, 1'b0);
        send_op(FUNC_ALLOC, 1'b0);
        send_op(FUNC_CLEAR, 1'b1);
        drain();

        load_partition_regs(4, 1, 64, 1);
        send_op(FUNC_CLEAR, 1'b0);
        repeat (3) send_op(FUNC_ALLOC, 1'b0);
        send_op(FUNC_FULLQ, 1'b0);
        send_op(FUNC_FREEQ, 1'b1);
        send_op(FUNC_TICK, 1'b0);
        send_op(FUNC_RELEASE, 1'b1);
        send_op(FUNC_TICK, 1'b1);
        send_op(FUNC_RELEASE, 1'b0);
        send_op(FUNC_FULLQ, 1'b1);
        send_op(FUNC_TICK, 1'b0);
        send_op(FUNC_RELEASE, 1'b1);
        drain();

        // build up full events, then hold the decision off with the widest interval
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_partition_regs(8, 1, 64, 16'hFFFF);
        send_op(FUNC_CLEAR, 1'b0);
        send_op(FUNC_TICK, 1'b0);
        send_op(FUNC_RELEASE, 1'b1);
        repeat (4) send_op(FUNC_ALLOC, 1'b0);
        repeat (4) send_op(FUNC_ALLOC, 1'b1);
        repeat (20) send_op(FUNC_FULLQ, 1'b0);
        repeat (8) send_op(FUNC_FREEQ, 1'b1);
        repeat (40) send_op(FUNC_TICK, 1'b1);
        send_op(FUNC_RELEASE, 1'b1);
        send_op(FUNC_FULLQ, 1'b0);
        send_op(FUNC_FREEQ, 1'b1);
        drain();

        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 55 : 0;
            rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 15 : 0;
            for (s = 0; s < 2; s++)
            begin
                drain();
                case (phase * 2 + s)
                    0: load_partition_regs(64, 1, 64, 1);
                    1: load_partition_regs(2, 64, 0, 3);
                    2: load_partition_regs(16, 2, 12, 2);
                    3: load_partition_regs(37, 5, 40, 1);
                    4: load_partition_regs($urandom_range(2, 16), $urandom_range(1, 4),
                                           $urandom_range(0, 64), $urandom_range(1, 8));
                    default: load_partition_regs($urandom_range(2, 64), $urandom_range(1, 64),
                                                 $urandom_range(0, 64), $urandom_range(1, 16));
                endcase
                if (s == 0 || $urandom_range(1) == 1)
                    send_op(FUNC_CLEAR, 1'($urandom_range(1)));
                if (phase == 0 && s == 0)
                    repeat (130) send_op(FUNC_ALLOC, 1'b1);
                run_random(50);
            end
        end

        drain();
        if (fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
